FILE: hw/rtl/adc_temperature_to_seven_segment_assert.svh
// Assertion macros shared by the block's modules.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ADC_TEMPERATURE_TO_SEVEN_SEGMENT_ASSERT_SVH
`define ADC_TEMPERATURE_TO_SEVEN_SEGMENT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ADC_TTS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ADC_TTS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/adc_tts_pkg.sv
package adc_tts_pkg;

    localparam int unsigned SAMPLE_W = 10;
    localparam int unsigned VALUE_W  = 10;
    localparam int unsigned SEG_W    = 8;
    localparam int unsigned NUM_W    = 23;

    // Scale and offset of the two conversions, in tenths of a degree.
    localparam logic [21:0] MUL_C = 22'd275;
    localparam logic [21:0] MUL_F = 22'd2475;
    localparam logic signed [NUM_W-1:0] OFS_C = 23'sd128000;
    localparam logic signed [NUM_W-1:0] OFS_F = 23'sd742400;

    // A numerator at or below these limits truncates to a negative value.
    localparam logic signed [NUM_W-1:0] NEG_LIM_C = -23'sd256;
    localparam logic signed [NUM_W-1:0] NEG_LIM_F = -23'sd1280;

    // Fahrenheit numerator from which the result reaches 100.0 degrees.
    localparam logic signed [NUM_W-1:0] OVER_F = 23'sd1280000;

    // Reciprocal of five, exact for quotients below 5000.
    localparam logic [28:0] RECIP_5 = 29'd52429;

    localparam logic [VALUE_W-1:0] TENTHS_MAX = 10'd999;

    localparam logic [SEG_W-1:0] SEG_DP     = 8'h80;
    localparam logic [SEG_W-1:0] SEG_UNIT_C = 8'h39;
    localparam logic [SEG_W-1:0] SEG_UNIT_F = 8'h71;

    // Clamped temperature passed from the converter to the encoder.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               flag;
    } temp_t;

    // One complete result beat.
    typedef struct packed {
        logic [SEG_W-1:0]   seg_tens;
        logic [SEG_W-1:0]   seg_ones;
        logic [SEG_W-1:0]   seg_tenths;
        logic [SEG_W-1:0]   seg_unit;
        logic [VALUE_W-1:0] tenths_value;
        logic               out_of_range;
    } result_t;

    // Seven-segment pattern of a decimal digit, bit0 segment a to bit6 segment g.
    function automatic logic [SEG_W-1:0] digit_pattern(input logic [3:0] digit);
        logic [SEG_W-1:0] pat;
        unique case (digit)
            4'd0:    pat = 8'h3F;
            4'd1:    pat = 8'h06;
            4'd2:    pat = 8'h5B;
            4'd3:    pat = 8'h4F;
            4'd4:    pat = 8'h66;
            4'd5:    pat = 8'h6D;
            4'd6:    pat = 8'h7D;
            4'd7:    pat = 8'h07;
            4'd8:    pat = 8'h7F;
            4'd9:    pat = 8'h67;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

endpackage

FILE: hw/rtl/adc_tts_if.sv
// Sample channel: one converter reading and the unit select per beat.
interface adc_tts_sample_if
    import adc_tts_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] adc_sample;
    logic                unit_select;

    modport source (output valid, output adc_sample, output unit_select, input ready);
    modport sink   (input valid, input adc_sample, input unit_select, output ready);
endinterface

// Result channel: display patterns and clamped value per beat.
interface adc_tts_result_if
    import adc_tts_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [SEG_W-1:0]   seg_tens;
    logic [SEG_W-1:0]   seg_ones;
    logic [SEG_W-1:0]   seg_tenths;
    logic [SEG_W-1:0]   seg_unit;
    logic [VALUE_W-1:0] tenths_value;
    logic               out_of_range;

    modport source (
        output valid, output seg_tens, output seg_ones, output seg_tenths,
        output seg_unit, output tenths_value, output out_of_range, input ready
    );
    modport sink (
        input valid, input seg_tens, input seg_ones, input seg_tenths,
        input seg_unit, input tenths_value, input out_of_range, output ready
    );
endinterface

FILE: hw/rtl/adc_tts_conv.sv
// Converts a sample to a clamped temperature in tenths of a degree.
module adc_tts_conv
    import adc_tts_pkg::*;
(
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                unit_select,
    output temp_t               temp
);

    logic [21:0]             prod;
    logic signed [NUM_W-1:0] num;
    logic                    below;
    logic                    above;
    logic [12:0]             quot_256;
    logic [28:0]             recip_prod;
    logic [VALUE_W-1:0]      quot;

    // Scaled numerator; both scales fit in 22 unsigned bits.
    always_comb
    begin
        if (unit_select)
        begin
            prod = 22'(sample) * MUL_F;
            num  = $signed({1'b0, prod}) - OFS_F;
        end
        else
        begin
            prod = 22'(sample) * MUL_C;
            num  = $signed({1'b0, prod}) - OFS_C;
        end
    end

    // Range checks on the numerator stand in for checks on the quotient.
    assign below = unit_select ? (num <= NEG_LIM_F) : (num <= NEG_LIM_C);
    assign above = unit_select && (num >= OVER_F);

    // Division by 256 is a shift; Fahrenheit then divides by five.
    assign quot_256   = num[20:8];
    assign recip_prod = 29'(quot_256) * RECIP_5;
    assign quot       = unit_select ? recip_prod[27:18] : num[17:8];

    // Clamp into the displayable range.
    always_comb
    begin
        if (num[NUM_W-1])
        begin
            temp.value = '0;
            temp.flag  = below;
        end
        else if (above)
        begin
            temp.value = TENTHS_MAX;
            temp.flag  = 1'b1;
        end
        else
        begin
            temp.value = quot;
            temp.flag  = 1'b0;
        end
    end

endmodule

FILE: hw/rtl/adc_tts_seg.sv
// Splits the clamped value into decimal digits and encodes the display patterns.
module adc_tts_seg
    import adc_tts_pkg::*;
(
    input  temp_t   temp,
    input  logic    unit_select,
    output result_t result
);

    logic [15:0] h_prod;
    logic [3:0]  hundreds;
    logic [17:0] q_prod;
    logic [6:0]  q10;
    logic [6:0]  h_times10;
    logic [9:0]  q10_times10;
    logic [3:0]  tens_d;
    logic [3:0]  ones_d;

    // Division by 100 and by 10 through reciprocals, exact below 1000.
    assign h_prod      = 16'(temp.value) * 16'd41;
    assign hundreds    = h_prod[15:12];
    assign q_prod      = 18'(temp.value) * 18'd205;
    assign q10         = q_prod[17:11];
    assign h_times10   = 7'(hundreds) * 7'd10;
    assign q10_times10 = 10'(q10) * 10'd10;
    assign tens_d      = 4'(q10 - h_times10);
    assign ones_d      = 4'(temp.value - q10_times10);

    // Patterns; the middle digit carries the decimal point.
    assign result.seg_tens     = digit_pattern(hundreds);
    assign result.seg_ones     = digit_pattern(tens_d) | SEG_DP;
    assign result.seg_tenths   = digit_pattern(ones_d);
    assign result.seg_unit     = unit_select ? SEG_UNIT_F : SEG_UNIT_C;
    assign result.tenths_value = temp.value;
    assign result.out_of_range = temp.flag;

endmodule

FILE: hw/rtl/adc_temperature_to_seven_segment.sv
// Converts one 10-bit sensor sample per beat into a temperature in tenths of a
// degree (Celsius or Fahrenheit by unit_select), clamped to 0.0..99.9 with
// out_of_range set when clamping took place, and into seven-segment patterns
// for three digits and the unit symbol. Every sample gives exactly one result.
// The block takes one beat per cycle while the result side keeps ready high: a
// sample passes an input register and the arithmetic, and its result is loaded
// into the result register, from which it is offered. Both registers stall in
// place while the result side holds ready low, and a new sample is taken
// whenever the input register empties or moves on in the same cycle.
`include "adc_temperature_to_seven_segment_assert.svh"

module adc_temperature_to_seven_segment
    import adc_tts_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    adc_tts_sample_if.sink          sample_ch,
    adc_tts_result_if.source        result_ch
);

    logic                stg_valid_reg;
    logic [SAMPLE_W-1:0] stg_sample_reg;
    logic                stg_unit_reg;
    logic                res_valid_reg;
    result_t             res_reg;
    logic                res_free;
    logic                stg_adv;
    logic                in_take;
    temp_t               temp;
    result_t             res_next;

    // Handshake: each register moves on when the one after it can take a beat.
    assign res_free        = !res_valid_reg || result_ch.ready;
    assign stg_adv         = stg_valid_reg && res_free;
    assign sample_ch.ready = !stg_valid_reg || res_free;
    assign in_take         = sample_ch.valid && sample_ch.ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (sample_ch.ready)
        begin
            stg_valid_reg <= sample_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            stg_sample_reg <= sample_ch.adc_sample;
            stg_unit_reg   <= sample_ch.unit_select;
        end
    end

    // Arithmetic and encoding.
    adc_tts_conv u_conv (
        .sample      (stg_sample_reg),
        .unit_select (stg_unit_reg),
        .temp        (temp)
    );

    adc_tts_seg u_seg (
        .temp        (temp),
        .unit_select (stg_unit_reg),
        .result      (res_next)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            res_valid_reg <= stg_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_adv)
        begin
            res_reg <= res_next;
        end
    end

    assign result_ch.valid        = res_valid_reg;
    assign result_ch.seg_tens     = res_reg.seg_tens;
    assign result_ch.seg_ones     = res_reg.seg_ones;
    assign result_ch.seg_tenths   = res_reg.seg_tenths;
    assign result_ch.seg_unit     = res_reg.seg_unit;
    assign result_ch.tenths_value = res_reg.tenths_value;
    assign result_ch.out_of_range = res_reg.out_of_range;

    // Checks on the pipeline and the clamping.
    `ADC_TTS_ASSERT_NXT(a_stg_hold, stg_valid_reg && !res_free, stg_valid_reg,
                        "input beat lost while stalled")
    `ADC_TTS_ASSERT_IMP(a_value_max, res_valid_reg, res_reg.tenths_value <= TENTHS_MAX,
                        "value above 99.9")
    `ADC_TTS_ASSERT_IMP(a_clamp_ends, res_valid_reg && res_reg.out_of_range,
                        res_reg.tenths_value == '0 || res_reg.tenths_value == TENTHS_MAX,
                        "flagged value not at a range end")
    `ADC_TTS_ASSERT_IMP(a_dp_only_ones, res_valid_reg,
                        res_reg.seg_ones[SEG_W-1] && !res_reg.seg_tens[SEG_W-1]
                            && !res_reg.seg_tenths[SEG_W-1],
                        "decimal point misplaced")

endmodule

FILE: dv/testbench.sv
module testbench
    import adc_tts_pkg::*;
();

    // Unit select codes.
    localparam logic UNIT_C = 1'b0;
    localparam logic UNIT_F = 1'b1;

    // Conversion to tenths of a degree: (scale * sample - offset) / divisor.
    localparam int SCALE_C  = 275;
    localparam int OFFSET_C = 128000;
    localparam int DIV_C    = 256;
    localparam int SCALE_F  = 2475;
    localparam int OFFSET_F = 742400;
    localparam int DIV_F    = 1280;
    localparam int MAX_TENTHS = 999;

    localparam int RANDOM_PER_PHASE = 300;
    localparam int NUM_PHASES       = 4;
    localparam int SETTLE_CYCLES    = 10;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int REPORT_LIMIT     = 10;

    // Segment patterns of the decimal digits, bit0 segment a to bit6 segment g.
    localparam logic [SEG_W-1:0] DIGIT_SEGS [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h67
    };

    // One beat awaiting its result, with the sample that caused it.
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                unit;
        result_t             display;
    } pending_t;

    // One row of the directed table; a fixed expectation is used where given.
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                unit;
        logic                fixed;
        result_t             want;
    } stim_row_t;

    localparam int NUM_DIRECTED = 21;

    // Extremes, both clamp directions, the truncation toward zero just under
    // zero in Celsius, the edge of 100.0 in Fahrenheit and alternating bits.
    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{10'd0,    UNIT_C, 1'b1, '{8'h3F, 8'hBF, 8'h3F, 8'h39, 10'd0,   1'b1}},
        '{10'd0,    UNIT_F, 1'b1, '{8'h3F, 8'hBF, 8'h3F, 8'h71, 10'd0,   1'b1}},
        '{10'd1023, UNIT_F, 1'b1, '{8'h67, 8'hE7, 8'h67, 8'h71, 10'd999, 1'b1}},
        '{10'd1023, UNIT_C, 1'b0, '0},
        '{10'd464,  UNIT_C, 1'b0, '0},
        '{10'd465,  UNIT_C, 1'b0, '0},
        '{10'd466,  UNIT_C, 1'b0, '0},
        '{10'd299,  UNIT_F, 1'b0, '0},
        '{10'd300,  UNIT_F, 1'b0, '0},
        '{10'd816,  UNIT_F, 1'b0, '0},
        '{10'd817,  UNIT_F, 1'b0, '0},
        '{10'd818,  UNIT_F, 1'b0, '0},
        '{10'd512,  UNIT_C, 1'b0, '0},
        '{10'd512,  UNIT_F, 1'b0, '0},
        '{10'd682,  UNIT_C, 1'b0, '0},
        '{10'd341,  UNIT_F, 1'b0, '0},
        '{10'd1,    UNIT_C, 1'b0, '0},
        '{10'd1022, UNIT_F, 1'b0, '0},
        '{10'd700,  UNIT_C, 1'b0, '0},
        '{10'd600,  UNIT_F, 1'b0, '0},
        '{10'd900,  UNIT_C, 1'b0, '0}
    };

    logic clk;
    logic rst_n;

    adc_tts_sample_if sample_ch ();
    adc_tts_result_if result_ch ();

    adc_temperature_to_seven_segment u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch)
    );

    pending_t    expected_display [$];
    int          fail_count  = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int unsigned cycle_count = 0;

    // Display expected for one sample: converted, clamped and encoded.
    function automatic result_t predict_display(logic [SAMPLE_W-1:0] sample, logic unit);
        int      numerator;
        int      tenths;
        result_t disp;
        if (unit == UNIT_F)
        begin
            numerator = SCALE_F * int'(sample) - OFFSET_F;
            tenths    = numerator / DIV_F;
        end
        else
        begin
            numerator = SCALE_C * int'(sample) - OFFSET_C;
            tenths    = numerator / DIV_C;
        end
        disp.out_of_range = 1'b0;
        if (tenths < 0)
        begin
            tenths            = 0;
            disp.out_of_range = 1'b1;
        end
        else if (tenths > MAX_TENTHS)
        begin
            tenths            = MAX_TENTHS;
            disp.out_of_range = 1'b1;
        end
        disp.tenths_value = VALUE_W'(tenths);
        disp.seg_tens     = DIGIT_SEGS[(tenths / 100) % 10];
        disp.seg_ones     = DIGIT_SEGS[(tenths / 10) % 10] | SEG_DP;
        disp.seg_tenths   = DIGIT_SEGS[tenths % 10];
        disp.seg_unit     = (unit == UNIT_F) ? SEG_UNIT_F : SEG_UNIT_C;
        return disp;
    endfunction

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("adc_temperature_to_seven_segment verification failed");
            $finish;
        end
    end

    // Result side: random stalls, and every accepted beat checked against the
    // oldest expectation.
    initial
    begin
        pending_t pend;
        result_t  got;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                got = '{result_ch.seg_tens, result_ch.seg_ones, result_ch.seg_tenths,
                        result_ch.seg_unit, result_ch.tenths_value,
                        result_ch.out_of_range};
                if (expected_display.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected result beat: %p", got);
                end
                else
                begin
                    pend = expected_display.pop_front();
                    if (got !== pend.display)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("mismatch sample %0d unit %0d: expected %p, got %p",
                                     pend.sample, pend.unit, pend.display, got);
                    end
                end
            end
            result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Offer one sample beat after a random gap and record its expectation once
    // it is accepted.
    task automatic send_reading(logic [SAMPLE_W-1:0] sample, logic unit,
                                logic fixed, result_t want);
        int       gap;
        pending_t pend;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.adc_sample  <= sample;
        sample_ch.unit_select <= unit;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        pend.sample  = sample;
        pend.unit    = unit;
        pend.display = fixed ? want : predict_display(sample, unit);
        expected_display.push_back(pend);
    endtask

    // Random sample, weighted toward the clamp and truncation edges.
    task automatic send_random_reading();
        logic [SAMPLE_W-1:0] sample;
        logic                unit;
        int                  pick;
        pick = $urandom_range(0, 9);
        unit = 1'($urandom_range(0, 1));
        if (pick <= 5)
            sample = SAMPLE_W'($urandom_range(0, 1023));
        else if (pick == 6)
        begin
            sample = SAMPLE_W'($urandom_range(455, 475));
            unit   = UNIT_C;
        end
        else if (pick == 7)
        begin
            sample = $urandom_range(0, 1) ? SAMPLE_W'($urandom_range(290, 310))
                                          : SAMPLE_W'($urandom_range(808, 828));
            unit   = UNIT_F;
        end
        else if (pick == 8)
            sample = $urandom_range(0, 1) ? SAMPLE_W'($urandom_range(0, 7))
                                          : SAMPLE_W'($urandom_range(1016, 1023));
        else
        begin
            sample = SAMPLE_W'($urandom_range(800, 1023));
            unit   = UNIT_F;
        end
        send_reading(sample, unit, 1'b0, '0);
    endtask

    // Let every outstanding beat come back with the sender quiet.
    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_display.size() != 0);
    endtask

    // Reset, directed table, then random phases with different idling.
    initial
    begin
        rst_n                 <= 1'b0;
        sample_ch.valid       <= 1'b0;
        sample_ch.adc_sample  <= '0;
        sample_ch.unit_select <= UNIT_C;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_reading(directed_rows[i].sample, directed_rows[i].unit,
                         directed_rows[i].fixed, directed_rows[i].want);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            repeat (RANDOM_PER_PHASE) send_random_reading();
            drain_results();
        end

        recv_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_display.size() == 0)
            $display("adc_temperature_to_seven_segment verification clean");
        else
            $display("adc_temperature_to_seven_segment verification failed");
        $finish;
    end

endmodule

FILE: adc_temperature_to_seven_segment.f
+incdir+hw/rtl
hw/rtl/adc_tts_pkg.sv
hw/rtl/adc_tts_if.sv
hw/rtl/adc_tts_conv.sv
hw/rtl/adc_tts_seg.sv
hw/rtl/adc_temperature_to_seven_segment.sv
dv/testbench.sv
